// ===== design/drn_pkg.sv =====
// Shared types and constants for the decimal normalize and round block.
package drn_pkg;

  localparam int unsigned LimbW     = 56;
  localparam int unsigned ChunkW    = 28;
  localparam int unsigned NumChunks = 8;
  localparam int unsigned IdxW      = $clog2(NumChunks);
  localparam int unsigned ScaleW    = 7;
  localparam int unsigned DigitW    = 4;

  localparam logic signed [ScaleW-1:0] MaxScale  = 7'sd28;
  localparam logic [DigitW-1:0]        HalfDigit = 4'd5;
  localparam logic [DigitW-1:0]        Ten       = 4'd10;

  // Reciprocal of ten, exact for every 32-bit dividend after a shift by 35.
  localparam logic [31:0]     RecipTen   = 32'hCCCC_CCCD;
  localparam int unsigned     RecipShift = 35;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusOvfPos = 2'd1;
  localparam logic [1:0] StatusOvfNeg = 2'd2;

  typedef logic [ChunkW-1:0] chunk_t;
  typedef logic [DigitW-1:0] digit_t;

  typedef struct packed {
    logic [LimbW-1:0] mant_w0;
    logic [LimbW-1:0] mant_w1;
    logic [LimbW-1:0] mant_w2;
    logic [LimbW-1:0] mant_w3;
    logic [5:0]       in_scale;
    logic             in_sign;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] res_low;
    logic [31:0] res_high;
    logic [4:0]  res_scale;
    logic        res_sign;
    logic [1:0]  status;
  } out_beat_t;

endpackage

// ===== design/drn_div10.sv =====
// One chunk step of a long division by ten: remainder in, quotient and remainder out.
module drn_div10 (
  input  drn_pkg::digit_t rem_i,
  input  drn_pkg::chunk_t chunk_i,
  output drn_pkg::chunk_t quot_o,
  output drn_pkg::digit_t rem_o
);
  import drn_pkg::*;

  logic [31:0] dividend;
  logic [63:0] product;
  digit_t      quot_ten;

  assign dividend = {rem_i, chunk_i};
  assign product  = dividend * RecipTen;
  assign quot_o   = product[RecipShift+ChunkW-1:RecipShift];
  assign quot_ten = digit_t'({quot_o[DigitW-2:0], 1'b0}) + digit_t'({quot_o[0], 3'b000});
  assign rem_o    = dividend[DigitW-1:0] - quot_ten;

endmodule

// ===== design/decimal_normalize_round.sv =====
// Top level: sequencer that normalizes and rounds a wide decimal value to 96 bits.
// Each normalizing divide-by-ten walks the active 28-bit chunks from the top one down,
// and a round-up that carries past 96 bits adds a carry divide over the active chunks.
// in_ready_o is high only while idle, so a new item is taken only once the last is done;
// every divide uses the shared 28-bit divide-by-ten step. A finished result waits in the
// output register while the next item is taken; rst_ni clears the sequencer and out valid.
module decimal_normalize_round (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  drn_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output drn_pkg::out_beat_t out_beat_o
);
  import drn_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StCheck  = 3'd1;
  localparam logic [2:0] StDiv    = 3'd2;
  localparam logic [2:0] StRound  = 3'd3;
  localparam logic [2:0] StCarry  = 3'd4;
  localparam logic [2:0] StFinish = 3'd5;

  logic [2:0]               state_q, state_d;
  chunk_t                   mant_q [NumChunks];
  chunk_t                   mant_d [NumChunks];
  logic signed [ScaleW-1:0] scale_q, scale_d;
  logic                     sign_q, sign_d;
  digit_t                   last_q, last_d;
  digit_t                   rem_q, rem_d;
  logic                     sticky_q, sticky_d;
  logic                     carry_pass_q, carry_pass_d;
  logic [IdxW-1:0]          idx_q, idx_d;
  logic                     out_valid_q, out_valid_d;
  out_beat_t                out_q, out_d;

  logic [IdxW-1:0]          top_idx;
  logic                     above_96;
  logic                     is_zero;
  logic                     round_up;
  logic [4*ChunkW-1:0]      low_sum;
  logic [223:0]             in_wide;
  chunk_t                   quot;
  digit_t                   rem_next;
  logic [1:0]               status;
  logic                     out_free;

  drn_div10 u_div10 (
    .rem_i  (rem_q),
    .chunk_i(mant_q[idx_q]),
    .quot_o (quot),
    .rem_o  (rem_next)
  );

  assign in_wide  = {in_beat_i.mant_w3, in_beat_i.mant_w2, in_beat_i.mant_w1, in_beat_i.mant_w0};
  assign above_96 = (mant_q[7] != '0) || (mant_q[6] != '0) || (mant_q[5] != '0) ||
                    (mant_q[4] != '0) || (mant_q[3][ChunkW-1:12] != '0);
  assign is_zero  = (mant_q[7] == '0) && (mant_q[6] == '0) && (mant_q[5] == '0) &&
                    (mant_q[4] == '0) && (mant_q[3] == '0) && (mant_q[2] == '0) &&
                    (mant_q[1] == '0) && (mant_q[0] == '0);
  assign round_up = (last_q > HalfDigit) ||
                    ((last_q == HalfDigit) && (sticky_q || mant_q[0][0]));
  assign low_sum  = {mant_q[3], mant_q[2], mant_q[1], mant_q[0]} + (4*ChunkW)'(1);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    top_idx = '0;
    for (int i = 1; i < NumChunks; i++) begin
      if (mant_q[i] != '0) begin
        top_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    if ((scale_q < 0) || above_96) begin
      status = sign_q ? StatusOvfNeg : StatusOvfPos;
    end else if (is_zero && ((last_q != '0) || sticky_q)) begin
      status = StatusOvfNeg;
    end else begin
      status = StatusOk;
    end
  end

  always_comb begin
    state_d      = state_q;
    mant_d       = mant_q;
    scale_d      = scale_q;
    sign_d       = sign_q;
    last_d       = last_q;
    rem_d        = rem_q;
    sticky_d     = sticky_q;
    carry_pass_d = carry_pass_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          for (int i = 0; i < NumChunks; i++) begin
            mant_d[i] = in_wide[i*ChunkW +: ChunkW];
          end
          scale_d      = ScaleW'(signed'({1'b0, in_beat_i.in_scale}));
          sign_d       = in_beat_i.in_sign;
          last_d       = '0;
          sticky_d     = 1'b0;
          carry_pass_d = 1'b0;
          state_d      = StCheck;
        end
      end
      StCheck: begin
        if (above_96 || (scale_q > MaxScale)) begin
          sticky_d = sticky_q || (last_q != '0);
          idx_d    = top_idx;
          rem_d    = '0;
          state_d  = StDiv;
        end else begin
          state_d = StRound;
        end
      end
      StDiv: begin
        mant_d[idx_q] = quot;
        rem_d         = rem_next;
        if (idx_q == '0) begin
          last_d  = rem_next;
          scale_d = scale_q - 7'sd1;
          state_d = carry_pass_q ? StFinish : StCheck;
        end else begin
          idx_d = idx_q - IdxW'(1);
        end
      end
      StRound: begin
        if (round_up) begin
          for (int i = 0; i < 4; i++) begin
            mant_d[i] = low_sum[i*ChunkW +: ChunkW];
          end
          state_d = StCarry;
        end else begin
          state_d = StFinish;
        end
      end
      StCarry: begin
        if (above_96) begin
          carry_pass_d = 1'b1;
          idx_d        = top_idx;
          rem_d        = '0;
          state_d      = StDiv;
        end else begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.status = status;
          if (status != StatusOk) begin
            out_d.res_low   = '0;
            out_d.res_high  = '0;
            out_d.res_scale = '0;
            out_d.res_sign  = 1'b0;
          end else begin
            out_d.res_low   = {mant_q[2][7:0], mant_q[1], mant_q[0]};
            out_d.res_high  = {mant_q[3][11:0], mant_q[2][ChunkW-1:8]};
            out_d.res_scale = scale_q[4:0];
            out_d.res_sign  = sign_q;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mant_q       <= mant_d;
    scale_q      <= scale_d;
    sign_q       <= sign_d;
    last_q       <= last_d;
    rem_q        <= rem_d;
    sticky_q     <= sticky_d;
    carry_pass_q <= carry_pass_d;
    idx_q        <= idx_d;
    out_q        <= out_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule
